// ----- sv/pixel_triplet_difference_stego_macros.svh -----
// Assertion macros shared by the pixel triplet stego RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PIXEL_TRIPLET_DIFFERENCE_STEGO_MACROS_SVH
`define PIXEL_TRIPLET_DIFFERENCE_STEGO_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PTDS_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("ptds assertion failed");

// Plain invariant checked on every clock edge outside reset.
`define PTDS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ptds invariant failed");

`endif

// ----- sv/ptds_pkg.sv -----
// Package for the pixel triplet stego block: payload structs, widths, constants.
// No dependencies.
`default_nettype none
package ptds_pkg;
    localparam int PIX_W = 8;
    localparam int CNT_W = 4;
    localparam int RNG_W = 11;  // signed range bounds
    localparam logic [CNT_W-1:0] MAX_N = 4'd8;
    localparam logic [0:0] OP_EMBED = 1'b0;
    localparam logic [0:0] OP_EXTRACT = 1'b1;
    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_MAX_BITS = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_left;
        logic [PIX_W-1:0] pixel_mid;
        logic [PIX_W-1:0] pixel_right;
        logic [PIX_W-1:0] secret_window;
        logic [CNT_W-1:0] bits_remaining;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] new_mid;
        logic [CNT_W-1:0] capacity;
        logic [CNT_W-1:0] bits_used;
        logic [PIX_W-1:0] extracted;
    } t_out;

    // Range of the middle pixel for one classified triplet.
    typedef struct packed {
        logic                    usable;
        logic signed [RNG_W-1:0] lo;
        logic signed [RNG_W-1:0] hi;
    } t_range;
endpackage
`default_nettype wire

// ----- sv/ptds_range.sv -----
// Triplet classification: threshold test, twelve shape cases, middle pixel range.
// Depends on ptds_pkg.
`default_nettype none
module ptds_range
    import ptds_pkg::*;
(
    input  wire logic [PIX_W-1:0] i_g0,
    input  wire logic [PIX_W-1:0] i_g1,
    input  wire logic [PIX_W-1:0] i_g2,
    input  wire logic [PIX_W-1:0] i_thr,
    output t_range                o_rng
);
    logic signed [RNG_W-1:0] g0, g1, g2, t, d0, d1, pmax;
    logic h0, h1;

    function automatic logic signed [RNG_W-1:0] f_max(input logic signed [RNG_W-1:0] a,
                                                      input logic signed [RNG_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [RNG_W-1:0] f_min(input logic signed [RNG_W-1:0] a,
                                                      input logic signed [RNG_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    always_comb begin
        g0   = $signed({{(RNG_W-PIX_W){1'b0}}, i_g0});
        g1   = $signed({{(RNG_W-PIX_W){1'b0}}, i_g1});
        g2   = $signed({{(RNG_W-PIX_W){1'b0}}, i_g2});
        t    = $signed({{(RNG_W-PIX_W){1'b0}}, i_thr});
        pmax = $signed({{(RNG_W-PIX_W){1'b0}}, {PIX_W{1'b1}}});
        d0   = (g1 >= g0) ? g1 - g0 : g0 - g1;
        d1   = (g2 >= g1) ? g2 - g1 : g1 - g2;
        h0   = d0 > t;
        h1   = d1 > t;
        o_rng.usable = h0 | h1;
        o_rng.lo = '0;
        o_rng.hi = '0;
        if (g1 < g0 && g1 < g2) begin
            if (h0 && h1) begin
                o_rng.lo = '0;
                o_rng.hi = f_min(g0 - t - RNG_W'(1), g2 - t - RNG_W'(1));
            end else if (h0) begin
                o_rng.lo = f_max(g2 - t, '0);
                o_rng.hi = f_min(g0 - t - RNG_W'(1), g2 - RNG_W'(1));
            end else begin
                o_rng.lo = f_max(g0 - t, '0);
                o_rng.hi = f_min(g2 - t - RNG_W'(1), g0 - RNG_W'(1));
            end
        end else if (g1 > g0 && g1 > g2) begin
            if (h0 && h1) begin
                o_rng.lo = f_max(g0 + t + RNG_W'(1), g2 + t + RNG_W'(1));
                o_rng.hi = pmax;
            end else if (h0) begin
                o_rng.lo = f_max(g0 + t + RNG_W'(1), g2 + RNG_W'(1));
                o_rng.hi = f_min(g2 + t, pmax);
            end else begin
                o_rng.lo = f_max(g2 + t + RNG_W'(1), g0 + RNG_W'(1));
                o_rng.hi = f_min(g0 + t, pmax);
            end
        end else if (g0 >= g1 && g1 >= g2) begin
            if (h0 && h1) begin
                o_rng.lo = g2 + t + RNG_W'(1);
                o_rng.hi = g0 - t - RNG_W'(1);
            end else if (h0) begin
                o_rng.lo = g2;
                o_rng.hi = f_min(g2 + t, g0 - t - RNG_W'(1));
            end else begin
                o_rng.lo = f_max(g2 + t + RNG_W'(1), g0 - t);
                o_rng.hi = g0;
            end
        end else begin
            if (h0 && h1) begin
                o_rng.lo = g0 + t + RNG_W'(1);
                o_rng.hi = g2 - t - RNG_W'(1);
            end else if (h0) begin
                o_rng.lo = f_max(g2 - t, g0 + t + RNG_W'(1));
                o_rng.hi = g2;
            end else begin
                o_rng.lo = g0;
                o_rng.hi = f_min(g2 - t - RNG_W'(1), g0 + t);
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/pixel_triplet_difference_stego.sv -----
// Top level of the pixel triplet stego block: three-stage pipeline and config registers.
// Depends on ptds_pkg, ptds_range and pixel_triplet_difference_stego_macros.svh.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  input    | i_start, o_busy           | i_in (t_in)
//  result   | o_res_valid (strobe)      | o_res (t_out)
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One triplet may enter in every cycle; the result strobe is registered through the
// three pipeline registers (range, capacity, selection).
// Reset is synchronous and active low; it clears the valid bits and restores the
// threshold to 5 and the bit limit to 3. The receiver cannot stall, so o_busy is
// always low and nothing in the pipeline ever waits.
`default_nettype none
`include "pixel_triplet_difference_stego_macros.svh"
module pixel_triplet_difference_stego
    import ptds_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire t_in              i_in,
    output logic                  o_res_valid,
    output t_out                  o_res,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [PIX_W-1:0] i_cfg_data
);
    // Configuration registers.
    logic [PIX_W-1:0] r_thr;
    logic [CNT_W-1:0] r_max_bits;

    // Stage 1: classified triplet.
    logic   r_v1;
    t_in    r_in1;
    t_range r_rng1;
    t_range n_rng1;

    // Stage 2: capacity, embed value and the search window in distance form.
    logic             r_v2, r_op2, r_up2;
    logic [PIX_W-1:0] r_g0_2, r_g1_2, r_d0_2, r_b2, r_c2, r_ulo2, r_uhi2;
    logic signed [PIX_W+1:0] r_tgt2;
    logic [CNT_W-1:0] r_n2, r_used2;

    // Output register.
    logic r_v3;
    t_out r_out3;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_v3;
    assign o_res       = r_out3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= 8'd5;
            r_max_bits <= 4'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_thr <= i_cfg_data;
                REG_MAX_BITS:  r_max_bits <= i_cfg_data[CNT_W-1:0];
                default:       r_thr <= r_thr;
            endcase
        end
    end

    ptds_range u_range (
        .i_g0  (i_in.pixel_left),
        .i_g1  (i_in.pixel_mid),
        .i_g2  (i_in.pixel_right),
        .i_thr (r_thr),
        .o_rng (n_rng1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        r_in1  <= i_in;
        r_rng1 <= n_rng1;
    end

    // Stage 2 logic. Every usable range lies wholly on one side of the left pixel,
    // so the search runs on the distance u = |e - left| with a fixed direction.
    logic signed [RNG_W-1:0] g0s, g1s, size2, ulo_s, uhi_s, tgt_s;
    logic [CNT_W-1:0] n_n2, kmax, log2, rem, n_used2;
    logic [PIX_W-1:0] n_b2, n_c2, n_d0;
    logic n_up2;

    always_comb begin
        g0s   = $signed({{(RNG_W-PIX_W){1'b0}}, r_in1.pixel_left});
        g1s   = $signed({{(RNG_W-PIX_W){1'b0}}, r_in1.pixel_mid});
        size2 = r_rng1.hi - r_rng1.lo + RNG_W'(1);
        log2  = '0;
        for (int k = 1; k <= PIX_W; k++) begin
            if (size2 >= (RNG_W'(1) << k)) begin
                log2 = CNT_W'(k);
            end
        end
        kmax = (r_max_bits > MAX_N) ? MAX_N : r_max_bits;
        n_n2 = '0;
        if (r_rng1.usable && r_rng1.hi >= r_rng1.lo) begin
            n_n2 = (log2 > kmax) ? kmax : log2;
        end
        rem     = (r_in1.bits_remaining > MAX_N) ? MAX_N : r_in1.bits_remaining;
        n_used2 = (r_in1.opcode == OP_EMBED) ? ((rem < n_n2) ? rem : n_n2) : '0;
        n_b2    = (r_in1.secret_window >> (MAX_N - n_used2)) << (n_n2 - n_used2);
        n_up2   = r_rng1.lo >= g0s;
        if (n_up2) begin
            ulo_s = r_rng1.lo - g0s;
            uhi_s = r_rng1.hi - g0s;
            tgt_s = g1s - g0s;
        end else begin
            ulo_s = g0s - r_rng1.hi;
            uhi_s = g0s - r_rng1.lo;
            tgt_s = g0s - g1s;
        end
        if (tgt_s < ulo_s) begin
            n_c2 = ulo_s[PIX_W-1:0];
        end else if (tgt_s > uhi_s) begin
            n_c2 = uhi_s[PIX_W-1:0];
        end else begin
            n_c2 = tgt_s[PIX_W-1:0];
        end
        n_d0 = (r_in1.pixel_mid >= r_in1.pixel_left) ? r_in1.pixel_mid - r_in1.pixel_left
                                                     : r_in1.pixel_left - r_in1.pixel_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_op2   <= r_in1.opcode;
        r_up2   <= n_up2;
        r_g0_2  <= r_in1.pixel_left;
        r_g1_2  <= r_in1.pixel_mid;
        r_d0_2  <= n_d0;
        r_b2    <= n_b2;
        r_c2    <= n_c2;
        r_ulo2  <= ulo_s[PIX_W-1:0];
        r_uhi2  <= uhi_s[PIX_W-1:0];
        r_tgt2  <= tgt_s[PIX_W+1:0];
        r_n2    <= n_n2;
        r_used2 <= n_used2;
    end

    // Stage 3: the two candidates with the wanted residue around the clamped target,
    // then the nearer one in range. Ties take the smaller pixel value.
    logic [PIX_W:0] mod_m, mask9;
    logic signed [PIX_W+2:0] ca, cb, da, db, tgt, e;
    logic va, vb, pick_b;
    t_out n_out3;

    always_comb begin
        mod_m = (PIX_W+1)'(1) << r_n2;
        mask9 = mod_m - 1'b1;
        tgt   = (PIX_W+3)'(r_tgt2);
        ca    = $signed({3'b0, (r_c2 & ~mask9[PIX_W-1:0]) | r_b2});
        if (ca > $signed({3'b0, r_c2})) begin
            ca = ca - $signed({2'b0, mod_m});
        end
        cb = ca + $signed({2'b0, mod_m});
        va = ca >= $signed({3'b0, r_ulo2});
        vb = cb <= $signed({3'b0, r_uhi2});
        da = (ca >= tgt) ? ca - tgt : tgt - ca;
        db = (cb >= tgt) ? cb - tgt : tgt - cb;
        if (va && vb) begin
            pick_b = (db < da) || (db == da && !r_up2);
        end else begin
            pick_b = vb;
        end
        e = pick_b ? cb : ca;
        n_out3.new_mid   = r_g1_2;
        n_out3.capacity  = r_n2;
        n_out3.bits_used = r_used2;
        n_out3.extracted = '0;
        if (r_n2 != '0) begin
            if (r_op2 == OP_EXTRACT) begin
                n_out3.extracted = r_d0_2 & mask9[PIX_W-1:0];
            end else if (va || vb) begin
                n_out3.new_mid = r_up2 ? r_g0_2 + e[PIX_W-1:0] : r_g0_2 - e[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_out3 <= n_out3;
    end

    // A result strobe is always preceded by its input transfer, carried through the valid registers.
    `PTDS_ASSERT_IMP(a_latency, o_res_valid, $past(i_start, 3))
    // Embed never consumes more bits than the triplet carries.
    `PTDS_ASSERT_IMP(a_used_cap, o_res_valid, o_res.bits_used <= o_res.capacity)
    // The recovered value fits in capacity bits.
    `PTDS_ASSERT_IMP(a_ext_width, o_res_valid, (o_res.extracted >> o_res.capacity) == 8'd0)
endmodule
`default_nettype wire
